// File: rtl/opr_pkg.sv
package opr_pkg;

   // field widths of the request and response words
   localparam int CMD_W  = 2;
   localparam int IDX_W  = 4;
   localparam int MASK_W = 16;
   localparam int CNT_W  = 5;

   localparam int NUM_BUTTONS_DEFAULT = 16;

   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [CNT_W-1:0] count_type;

   // command codes, code 3 behaves as status only
   localparam cmd_type CMD_PRESS  = 2'd0;
   localparam cmd_type CMD_CLEAR  = 2'd1;
   localparam cmd_type CMD_STATUS = 2'd2;

   localparam count_type BUTTONS_IN_USE_RESET = 5'd16;

endpackage

// File: rtl/opr_if.sv
interface opr_req_if import opr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [IDX_W-1:0] button_index;

   modport source (output valid, output command, output button_index, input ready);
   modport sink   (input valid, input command, input button_index, output ready);
endinterface

interface opr_rsp_if import opr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              first_lit_valid;
   logic [IDX_W-1:0]  first_lit_index;
   logic              any_lit;
   logic [MASK_W-1:0] lit_mask;

   modport source (output valid, output first_lit_valid, output first_lit_index,
                   output any_lit, output lit_mask, input ready);
   modport sink   (input valid, input first_lit_valid, input first_lit_index,
                   input any_lit, input lit_mask, output ready);
endinterface

// File: rtl/oldest_first_request_panel.sv
// Oldest-first request panel. Each request word presses, clears or just polls one
// button; each word gives exactly one response word holding the oldest lit button,
// an any-lit flag and the lit mask as they stand after that word. Press order is
// kept in an age matrix (row i holds the buttons that i is older than), so the
// oldest lit button is the one whose row covers every other lit button. A word
// passes the input register, then its state update and oldest-button search go
// into the response register; one word is taken every cycle unless the response
// channel stalls, as lit flags and age matrix update combinationally. Presses and
// clears at or above csr_wdata's button count are ignored. The user, not the block,
// sees that the count is written through csr_we/csr_wdata while no word is in flight.
module oldest_first_request_panel import opr_pkg::*; #(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   opr_req_if.sink           req_chan,
   opr_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  logic [CNT_W-1:0]  csr_wdata
);

   // lit vector padded so the 16-bit mask can always be sliced from it
   localparam int WIDE_W = (NUM_BUTTONS > MASK_W) ? NUM_BUTTONS : MASK_W;

   // configuration
   count_type            buttons_ff;

   // input register
   logic                 s1_valid_ff;
   cmd_type              s1_cmd_ff;
   logic [IDX_W-1:0]     s1_idx_ff;

   // panel state
   logic [NUM_BUTTONS-1:0] lit_ff;
   logic [NUM_BUTTONS-1:0] lit_in;
   logic [NUM_BUTTONS-1:0] older_ff [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] older_in [NUM_BUTTONS];

   // response register
   logic                 rsp_valid_ff;
   logic                 first_valid_ff;
   logic [IDX_W-1:0]     first_index_ff;
   logic                 any_lit_ff;
   logic [MASK_W-1:0]    lit_mask_ff;

   // datapath signals
   logic                   req_fire;
   logic                   rsp_can_load;
   logic                   s1_fire;
   logic [NUM_BUTTONS-1:0] hit;
   logic                   idx_in_use;
   logic                   act;
   logic                   found;
   logic [IDX_W-1:0]       first_idx;
   logic [WIDE_W-1:0]      lit_wide;

   // handshakes: the input register moves whenever the response register is free or being read
   assign rsp_can_load   = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && rsp_can_load;
   assign req_chan.ready = !s1_valid_ff || rsp_can_load;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // one-hot decode of the named button, empty beyond the panel width
   always_comb begin
      for (int k = 0; k < NUM_BUTTONS; k++) begin
         hit[k] = (int'(s1_idx_ff) == k);
      end
   end

   // index must also sit below the configured count
   assign idx_in_use = ({1'b0, s1_idx_ff} < buttons_ff);
   assign act        = s1_fire && idx_in_use;

   // state update: a press of an unlit button makes it the youngest, a clear unlights it
   always_comb begin
      lit_in   = lit_ff;
      older_in = older_ff;
      if (act) begin
         case (s1_cmd_ff)
            CMD_PRESS: begin
               if ((lit_ff & hit) == '0) begin
                  lit_in = lit_ff | hit;
                  for (int j = 0; j < NUM_BUTTONS; j++) begin
                     if (hit[j]) begin
                        older_in[j] = '0;
                     end else begin
                        older_in[j] = older_ff[j] | hit;
                     end
                  end
               end
            end
            CMD_CLEAR: begin
               lit_in = lit_ff & ~hit;
            end
            default: begin
            end
         endcase
      end
   end

   // oldest lit button: its row covers all other lit buttons, lowest index wins
   always_comb begin
      found     = 1'b0;
      first_idx = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (lit_in[i] &&
             ((older_in[i] & (lit_in & ~(NUM_BUTTONS'(1) << i))) ==
              (lit_in & ~(NUM_BUTTONS'(1) << i)))) begin
            found     = 1'b1;
            first_idx = IDX_W'(i);
         end
      end
   end

   assign lit_wide = WIDE_W'(lit_in);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         buttons_ff <= BUTTONS_IN_USE_RESET;
      end else if (csr_we) begin
         buttons_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff <= req_chan.command;
         s1_idx_ff <= req_chan.button_index;
      end
   end

   // lit flags and age matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff <= '0;
         for (int r = 0; r < NUM_BUTTONS; r++) begin
            older_ff[r] <= '0;
         end
      end else begin
         lit_ff   <= lit_in;
         older_ff <= older_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         first_valid_ff <= found;
         first_index_ff <= first_idx;
         any_lit_ff     <= |lit_in;
         lit_mask_ff    <= lit_wide[MASK_W-1:0];
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.first_lit_valid = first_valid_ff;
   assign rsp_chan.first_lit_index = first_index_ff;
   assign rsp_chan.any_lit         = any_lit_ff;
   assign rsp_chan.lit_mask        = lit_mask_ff;

   // a lit panel always has an oldest button
   a_oldest_exists: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (any_lit_ff == first_valid_ff))
      else $error("lit panel without an oldest button");

   // the reported oldest button is lit
   a_oldest_is_lit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && first_valid_ff) |-> lit_mask_ff[first_index_ff])
      else $error("oldest button not in lit mask");

   // an in-range press leaves the button lit
   a_press_lights: assert property (@(posedge clock) disable iff (reset)
      (act && (s1_cmd_ff == CMD_PRESS) && (hit != '0)) |=> ((lit_ff & $past(hit)) != '0))
      else $error("press did not light the button");

endmodule

// File: tb/sv/panel_status_checker.sv
`timescale 1ns / 1ps
module panel_status_checker import opr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   opr_req_if        req_mon,
   opr_rsp_if        rsp_mon,
   input  logic      csr_we,
   input  count_type csr_wdata,
   output int        mismatches,
   output int        outstanding,
   output int        words_checked
);

   localparam int NB = NUM_BUTTONS_DEFAULT;

   typedef struct packed {
      logic              first_lit_valid;
      logic [IDX_W-1:0]  first_lit_index;
      logic              any_lit;
      logic [MASK_W-1:0] lit_mask;
   } panel_status_type;

   count_type        panel_size;
   logic [NB-1:0]    lit;
   logic [NB-1:0]    pressed_before [NB];  // row i: buttons that i was pressed before
   panel_status_type awaited_status [$];

   // applies one request word to the shadow panel and returns the status it leaves
   function automatic panel_status_type apply_button_word(cmd_type cmd, logic [IDX_W-1:0] idx);
      int               limit;
      logic [NB-1:0]    others;
      panel_status_type s;
      limit = (panel_size > NB) ? NB : int'(panel_size);
      if (int'(idx) < limit) begin
         if (cmd == CMD_PRESS && !lit[idx]) begin
            lit[idx] = 1'b1;
            pressed_before[idx] = '0;
            for (int j = 0; j < NB; j++)
               if (j != int'(idx)) pressed_before[j][idx] = 1'b1;
         end else if (cmd == CMD_CLEAR) begin
            lit[idx] = 1'b0;
         end
      end
      s = '0;
      for (int i = 0; i < NB; i++) begin
         others = lit & ~(NB'(1) << i);
         if (lit[i] && !s.first_lit_valid && (pressed_before[i] & others) == others) begin
            s.first_lit_valid = 1'b1;
            s.first_lit_index = IDX_W'(i);
         end
      end
      s.any_lit  = |lit;
      s.lit_mask = lit[MASK_W-1:0];
      return s;
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      panel_status_type want;
      if (reset) begin
         panel_size = BUTTONS_IN_USE_RESET;
         lit = '0;
         for (int i = 0; i < NB; i++) pressed_before[i] = '0;
         awaited_status.delete();
         mismatches = 0;
         words_checked = 0;
      end else begin
         // a response word always belongs to an earlier request word
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_status.size() == 0) begin
               $display("%0t ns: unexpected response word, expected nothing, actual mask %0d",
                        $time, rsp_mon.lit_mask);
               mismatches++;
            end else begin
               want = awaited_status.pop_front();
               check_field("first_lit_valid", want.first_lit_valid, rsp_mon.first_lit_valid);
               check_field("first_lit_index", want.first_lit_index, rsp_mon.first_lit_index);
               check_field("any_lit", want.any_lit, rsp_mon.any_lit);
               check_field("lit_mask", want.lit_mask, rsp_mon.lit_mask);
               words_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_status = {awaited_status,
                              apply_button_word(req_mon.command, req_mon.button_index)};
         if (csr_we) panel_size = csr_wdata;
      end
      outstanding <= awaited_status.size();
   end

endmodule

// File: tb/sv/oldest_first_request_panel_test.sv
`timescale 1ns / 1ps
module oldest_first_request_panel_test;
   import opr_pkg::*;

   // code 3 has no name in the package, the block treats it as status only
   localparam cmd_type CMD_SPARE = 2'd3;
   localparam int WORDS_PER_SEGMENT = 50;
   // button counts for the random segments: reset value, both extremes of the
   // register, zero, counts above the panel and a few in between
   localparam count_type SIZE_PLAN [9] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd9,
                                           5'd17, 5'd12, 5'd16};

   logic      clock;
   logic      reset;
   logic      csr_we;
   count_type csr_wdata;
   count_type panel_size_now;
   int        send_idle_pct;
   int        take_idle_pct;
   int        mismatches;
   int        outstanding;
   int        words_checked;
   int        words_sent;
   int        sizes_written;
   int        drain_cycles;

   opr_req_if req_bus ();
   opr_rsp_if rsp_bus ();

   oldest_first_request_panel dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // watches both channels and the count register, predicts and compares
   panel_status_checker status_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side stalls at random, held low through reset
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= take_idle_pct);
   end

   // hand one request word over; valid stays high afterwards so back-to-back
   // words never lower and raise it in the same step
   task automatic send_word(cmd_type cmd, logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.button_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   // stop sending and wait for every expected response word to come back
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // margin past the input and response registers before touching the register
      repeat (3) @(posedge clock);
   endtask

   // count register only changes while nothing is in flight
   task automatic set_panel_size(count_type n);
      wait_until_drained();
      csr_we    <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we <= 1'b0;
      panel_size_now = n;
      sizes_written++;
   endtask

   // mostly presses and clears, some status polls and the spare code
   function automatic cmd_type pick_command();
      int r;
      r = $urandom_range(99);
      if (r < 48) return CMD_PRESS;
      if (r < 83) return CMD_CLEAR;
      if (r < 93) return CMD_STATUS;
      return CMD_SPARE;
   endfunction

   // mostly buttons on the panel, the rest anywhere in the index range
   function automatic logic [IDX_W-1:0] pick_button(count_type n);
      int reach;
      reach = (n > 16) ? 16 : int'(n);
      if (reach > 0 && $urandom_range(99) < 85) return IDX_W'($urandom_range(reach - 1, 0));
      return IDX_W'($urandom_range(15, 0));
   endfunction

   initial begin
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_wdata            <= BUTTONS_IN_USE_RESET;
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_STATUS;
      req_bus.button_index <= '0;
      panel_size_now = BUTTONS_IN_USE_RESET;
      send_idle_pct  = 29;
      take_idle_pct  = 74;
      words_sent     = 0;
      sizes_written  = 0;
      drain_cycles   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty panel, both end buttons, press on a lit button,
      // spare code, clears that hand the oldest slot on, clear of an unlit button
      send_word(CMD_STATUS, 4'd15);
      send_word(CMD_PRESS, 4'd0);
      send_word(CMD_PRESS, 4'd15);
      send_word(CMD_PRESS, 4'd0);
      send_word(CMD_PRESS, 4'd7);
      send_word(CMD_SPARE, 4'd7);
      send_word(CMD_CLEAR, 4'd0);
      send_word(CMD_CLEAR, 4'd15);
      send_word(CMD_CLEAR, 4'd7);
      send_word(CMD_CLEAR, 4'd7);
      send_word(CMD_PRESS, 4'd15);
      send_word(CMD_PRESS, 4'd0);
      // count lowered while button 15 is lit: it stays lit but is locked out
      set_panel_size(5'd4);
      send_word(CMD_PRESS, 4'd15);
      send_word(CMD_CLEAR, 4'd15);
      send_word(CMD_PRESS, 4'd3);
      send_word(CMD_PRESS, 4'd4);
      // zero count: every press and clear ignored
      set_panel_size(5'd0);
      send_word(CMD_PRESS, 4'd2);
      send_word(CMD_CLEAR, 4'd3);
      // count above the panel acts as the full panel
      set_panel_size(5'd31);
      send_word(CMD_CLEAR, 4'd15);
      send_word(CMD_PRESS, 4'd15);
      send_word(CMD_CLEAR, 4'd0);
      send_word(CMD_CLEAR, 4'd3);

      // random: receiver mostly idles, then the sender, then neither
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 74 : 0;
         take_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 29 : 0;
         for (int seg = 0; seg < 3; seg++) begin
            set_panel_size(SIZE_PLAN[phase * 3 + seg]);
            repeat (WORDS_PER_SEGMENT) send_word(pick_command(), pick_button(panel_size_now));
         end
      end

      // drain with a cap, then let the pipeline settle
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      if (outstanding != 0)
         $display("%0t ns: %0d expected response words never arrived", $time, outstanding);
      $display("run covered %0d request words over %0d button-count settings",
               words_sent, sizes_written);
      $display("%0d response words compared, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("oldest_first_request_panel_test: PASS");
      else
         $display("oldest_first_request_panel_test: FAIL");
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("%0t ns: run did not finish in time", $time);
      $display("oldest_first_request_panel_test: FAIL");
      $finish;
   end

endmodule
